FILE: hdl/sjisu_pkg.sv
`default_nettype none

package sjisu_pkg;

   // table memory geometry
   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // operation codes carried by a request word
   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD   = 2'd0;
   localparam op_type OP_DECODE = 2'd1;
   localparam op_type OP_ENCODE = 2'd2;
   localparam op_type OP_NONE   = 2'd3;

   // how a looked-up table word turns into response words
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_WORD = 2'd0;  // full 16-bit unit, one word
   localparam kind_type KIND_LOW  = 2'd1;  // low byte only, one word
   localparam kind_type KIND_PAIR = 2'd2;  // high byte then low byte

   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   typedef struct packed {
      logic [7:0]  left;
      logic [7:0]  top;
      logic [7:0]  width;
      logic [8:0]  height;
      logic [15:0] base;
   } region_type;

   localparam int SJIS_COUNT = 4;
   localparam int UNI_COUNT  = 8;

   localparam region_type SJIS_REGIONS [SJIS_COUNT] = '{
      '{8'h00, 8'h00, 8'd1,  9'h0E0, 16'd0},
      '{8'h81, 8'h40, 8'd31, 9'h0BD, 16'd224},
      '{8'hE0, 8'h40, 8'd15, 9'h0BD, 16'd6083},
      '{8'hFA, 8'h40, 8'd2,  9'h0BD, 16'd8918}
   };

   localparam region_type UNI_REGIONS [UNI_COUNT] = '{
      '{8'h00, 8'h00, 8'd1,  9'h0F8, 16'd9296},
      '{8'h03, 8'h91, 8'd1,  9'h039, 16'd9544},
      '{8'h04, 8'h01, 8'd1,  9'h051, 16'd9601},
      '{8'h20, 8'h00, 8'd7,  9'h0EA, 16'd9682},
      '{8'h2F, 8'h00, 8'd5,  9'h0FF, 16'd11320},
      '{8'h4E, 8'h00, 8'd81, 9'h100, 16'd12595},
      '{8'hF9, 8'h0E, 8'd2,  9'h0CF, 16'd33331},
      '{8'hFF, 8'h01, 8'd1,  9'h0E5, 16'd33745}
   };

   // lookup outcome: zero forces the result word to 0
   typedef struct packed {
      logic              zero;
      logic [ADDR_W-1:0] addr;
   } lookup_type;

   // control handed from the read stage to the response stage
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } stage_type;

endpackage

`default_nettype wire

FILE: hdl/sjisu_ifs.sv
`default_nettype none

interface sjisu_req_if;
   logic                valid;
   logic                ready;
   sjisu_pkg::op_type   operation;
   logic [15:0]         data;
   logic [15:0]         table_address;

   modport source(output valid, output operation, output data, output table_address,
                  input ready);
   modport sink(input valid, input operation, input data, input table_address,
                output ready);
endinterface

interface sjisu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;
   logic        last;

   modport source(output valid, output value, output last, input ready);
   modport sink(input valid, input value, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sjisu_table_ram.sv
`default_nettype none

module sjisu_table_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [sjisu_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]                 wr_data,
   input  wire logic                        rd_en,
   input  wire logic [sjisu_pkg::ADDR_W-1:0] rd_addr,
   output logic      [15:0]                 rd_data
);
   import sjisu_pkg::*;

   logic [15:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/sjisu_region_lookup.sv
`default_nettype none

module sjisu_region_lookup (
   input  wire logic                  tables_ready,
   input  wire logic                  unicode,
   input  wire logic [7:0]            hi,
   input  wire logic [7:0]            lo,
   output sjisu_pkg::lookup_type      result
);
   import sjisu_pkg::*;

   logic        hit;
   region_type  sel;
   logic [7:0]  row;
   logic [7:0]  col;
   logic [16:0] sum;

   function automatic logic in_region(region_type r, logic [7:0] h, logic [7:0] l);
      logic h_ok;
      logic l_ok;
      h_ok = (h >= r.left) && (9'(h) < 9'(r.left) + 9'(r.width));
      l_ok = (l >= r.top) && (10'(l) < 10'(r.top) + 10'(r.height));
      return h_ok && l_ok;
   endfunction

   // walk from the last rectangle down so that the first one that holds the point wins
   always_comb begin
      hit = 1'b0;
      sel = '0;
      if (unicode) begin
         for (int i = UNI_COUNT - 1; i >= 0; i--) begin
            if (in_region(UNI_REGIONS[i], hi, lo)) begin
               hit = 1'b1;
               sel = UNI_REGIONS[i];
            end
         end
      end else begin
         for (int i = SJIS_COUNT - 1; i >= 0; i--) begin
            if (in_region(SJIS_REGIONS[i], hi, lo)) begin
               hit = 1'b1;
               sel = SJIS_REGIONS[i];
            end
         end
      end
   end

   assign row = lo - sel.top;
   assign col = hi - sel.left;
   assign sum = 17'(sel.base) + 17'(row) + 17'(sel.height) * 17'(col);

   assign result.zero = !tables_ready || !hit;
   assign result.addr = sum[ADDR_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/sjisu_result_stage.sv
`default_nettype none

module sjisu_result_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  sjisu_pkg::stage_type     stage,
   input  wire logic [15:0]         word,
   output logic                     stage_ready,
   sjisu_rsp_if.source              rsp_chan
);
   import sjisu_pkg::*;

   logic        valid_ff,   valid_in;
   logic [15:0] value_ff,   value_in;
   logic        last_ff,    last_in;
   logic        second_ff,  second_in;
   logic [7:0]  low_ff,     low_in;
   logic        take;

   assign take        = valid_ff && rsp_chan.ready;
   assign stage_ready = !valid_ff || (rsp_chan.ready && !second_ff);

   always_comb begin
      valid_in  = valid_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      second_in = second_ff;
      low_in    = low_ff;
      if (take && second_ff) begin
         // advance to the held low byte
         value_in  = {8'h00, low_ff};
         last_in   = 1'b1;
         second_in = 1'b0;
      end else if (stage.valid && stage_ready) begin
         valid_in = 1'b1;
         unique case (stage.kind)
            KIND_WORD: begin
               value_in = word;
               last_in  = 1'b1;
            end
            KIND_LOW: begin
               value_in = {8'h00, word[7:0]};
               last_in  = 1'b1;
            end
            KIND_PAIR: begin
               value_in  = {8'h00, word[15:8]};
               last_in   = 1'b0;
               second_in = 1'b1;
               low_in    = word[7:0];
            end
            default: begin
               value_in = word;
               last_in  = 1'b1;
            end
         endcase
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      last_ff  <= last_in;
      low_ff   <= low_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.value = value_ff;
   assign rsp_chan.last  = last_ff;

   a_second_shown: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (valid_ff && !last_ff))
      else $error("held low byte without its high byte on show");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (take && second_ff) |=> (valid_ff && last_ff && !second_ff))
      else $error("low byte did not follow high byte");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_chan.ready) |=>
         (valid_ff && $stable(value_ff) && $stable(last_ff)))
      else $error("response word changed while stalled");

endmodule

`default_nettype wire

FILE: hdl/sjis_unicode_region_table_converter_top.sv
`default_nettype none

// Path: a word that yields a result passes the table read, then the response register,
//   before it shows on rsp; the low byte of a pair follows in the cycle after its high byte is taken.
// Throughput: one request word per cycle unless the response side stalls, set by the single
//   table read port; an encode above 0x7F holds the single response register for both words of its pair.
// Reset: synchronous, active high; clears the pipeline, the held lead byte and
//   tables_ready. The table memory is not cleared and holds garbage until loaded.
module sjis_unicode_region_table_converter_top (
   input  wire logic   clock,
   input  wire logic   reset,
   sjisu_req_if.sink   req_chan,
   sjisu_rsp_if.source rsp_chan,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);
   import sjisu_pkg::*;

   // configuration
   logic tables_ready_ff;

   // Shift-JIS lead byte awaiting its trail byte
   logic       lead_pending_ff, lead_pending_in;
   logic [7:0] held_lead_ff,    held_lead_in;

   // read stage: lookup issued, table word arriving from memory
   logic     s1_valid_ff, s1_valid_in;
   kind_type s1_kind_ff,  s1_kind_in;
   logic     s1_zero_ff,  s1_zero_in;

   logic       accept;
   logic       out_ready;
   logic       needs_lookup;
   logic       unicode;
   logic [7:0] hi;
   logic [7:0] lo;
   kind_type   kind;
   lookup_type look;
   logic       wr_en;
   logic [15:0] rd_data;
   logic [15:0] word;
   stage_type   stage;

   // accept while the read stage is empty or drains this cycle
   assign req_chan.ready = !s1_valid_ff || out_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // classify the request word and pick the lookup point
   always_comb begin
      needs_lookup    = 1'b0;
      unicode         = 1'b0;
      hi              = 8'h00;
      lo              = req_chan.data[7:0];
      kind            = KIND_WORD;
      lead_pending_in = lead_pending_ff;
      held_lead_in    = held_lead_ff;
      unique case (req_chan.operation)
         OP_DECODE: begin
            if (lead_pending_ff) begin
               // pair the held lead with this byte, whatever its value
               needs_lookup    = 1'b1;
               hi              = held_lead_ff;
               lead_pending_in = 1'b0;
            end else if (req_chan.data[7:0] < ASCII_LIMIT) begin
               needs_lookup = 1'b1;
            end else begin
               // hold as lead; no word out yet
               held_lead_in    = req_chan.data[7:0];
               lead_pending_in = 1'b1;
            end
         end
         OP_ENCODE: begin
            needs_lookup = 1'b1;
            unicode      = 1'b1;
            hi           = req_chan.data[15:8];
            kind         = (req_chan.data < 16'(ASCII_LIMIT)) ? KIND_LOW : KIND_PAIR;
         end
         OP_LOAD, OP_NONE: begin
            needs_lookup = 1'b0;
         end
         default: begin
            needs_lookup = 1'b0;
         end
      endcase
   end

   sjisu_region_lookup u_lookup (
      .tables_ready (tables_ready_ff),
      .unicode      (unicode),
      .hi           (hi),
      .lo           (lo),
      .result       (look)
   );

   // Loads write at acceptance; a lookup reads at its own acceptance edge, so
   // accesses stay in request order and never meet in one cycle.
   assign wr_en = accept && (req_chan.operation == OP_LOAD) &&
                  (17'(req_chan.table_address) < 17'(TABLE_DEPTH));

   sjisu_table_ram u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_chan.table_address[ADDR_W-1:0]),
      .wr_data (req_chan.data),
      .rd_en   (accept && needs_lookup),
      .rd_addr (look.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_zero_in  = s1_zero_ff;
      if (accept) begin
         s1_valid_in = needs_lookup;
         s1_kind_in  = kind;
         s1_zero_in  = look.zero;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tables_ready_ff <= 1'b0;
         lead_pending_ff <= 1'b0;
         held_lead_ff    <= 8'h00;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tables_ready_ff <= csr_wr_data;
         end
         if (accept) begin
            lead_pending_ff <= lead_pending_in;
            held_lead_ff    <= held_lead_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_zero_ff <= s1_zero_in;
   end

   // drop the table word where no rectangle held the point or tables are not ready
   assign word        = s1_zero_ff ? 16'h0000 : rd_data;
   assign stage.valid = s1_valid_ff;
   assign stage.kind  = s1_kind_ff;

   sjisu_result_stage u_result (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .word        (word),
      .stage_ready (out_ready),
      .rsp_chan    (rsp_chan)
   );

   a_lookup_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && needs_lookup) |=> s1_valid_ff)
      else $error("lookup word lost before the read stage");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && !out_ready))
      else $error("request stalled with the read stage free");

   a_lead_held: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.operation == OP_DECODE) && !lead_pending_ff &&
       !(req_chan.data[7:0] < ASCII_LIMIT)) |=> (lead_pending_ff && !s1_valid_in ||
       lead_pending_ff))
      else $error("lead byte not held");

endmodule

`default_nettype wire
